// ===== src/bcf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types and codes for the bootloader command framer.
// ----------------------------------------------------------------------------
package bcf_pkg;

   // Largest data block accepted by block begin
   localparam int MAX_BLOCK_DEF = 256;

   // Most results one item can cause
   localparam int MAX_RESULTS = 5;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // Request opcodes
   localparam logic [2:0] OP_COMMAND     = 3'd0;
   localparam logic [2:0] OP_ADDRESS     = 3'd1;
   localparam logic [2:0] OP_BLOCK_BEGIN = 3'd2;
   localparam logic [2:0] OP_BLOCK_DATA  = 3'd3;
   localparam logic [2:0] OP_ERASE_BEGIN = 3'd4;
   localparam logic [2:0] OP_ERASE_PAGE  = 3'd5;
   localparam logic [2:0] OP_RX_BYTE     = 3'd6;
   localparam logic [2:0] OP_MASS_ERASE  = 3'd7;

   // Result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_ACK    = 2'd1;
   localparam logic [1:0] KIND_NACK   = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   // Frame phases
   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_BLOCK     = 2'd1;
   localparam logic [1:0] PH_ERASE_STD = 2'd2;
   localparam logic [1:0] PH_ERASE_EXT = 2'd3;

   // Protocol constants
   localparam logic [7:0]  ACK_CODE      = 8'h79;
   localparam logic [15:0] EXT_MAX_COUNT = 16'hFFF0;
   localparam logic [7:0]  FILL_BYTE     = 8'hFF;
   localparam logic [7:0]  ZERO_BYTE     = 8'h00;
   localparam logic [15:0] STD_MAX_PAGE  = 16'd255;

   // One classified item: a run of results for the back end
   typedef struct packed {
      logic [1:0]                         kind;
      logic [CNT_W-1:0]                   cnt;
      logic [MAX_RESULTS-1:0][7:0]        tx_bytes;
   } job_type;

endpackage

// ===== src/bootloader_command_framer.sv =====
// ----------------------------------------------------------------------------
// bootloader_command_framer
// Frames bootloader requests into serial transmit bytes with XOR checksums.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | op, value_byte, address, ...
//  rsp_    | out       | rsp_valid/rsp_stall | kind, tx_byte, last
//  csr_    | in        | csr_wr_en           | csr_wr_data (extended_erase)
//
// One result leaves per cycle while rsp_stall is low; an item yields 0 to 5
// results via the back end's output register. The front end classifies an
// item in its accept cycle and a two-entry job queue lets it run up to two
// items ahead. The first result passes the job queue, the back end's job
// register and output register. Synchronous reset closes any open frame
// and clears extended_erase. req_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module bootloader_command_framer #(
   parameter int MAX_BLOCK = bcf_pkg::MAX_BLOCK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_value_byte,
   input  logic [31:0] req_address,
   input  logic [8:0]  req_block_length,
   input  logic [15:0] req_first_page,
   input  logic [15:0] req_page_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last
);

   logic             accept;
   logic             job_push;
   bcf_pkg::job_type push_job;
   logic             q_full;
   logic             q_valid;
   bcf_pkg::job_type head_job;
   logic             q_pop;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Front end: classify items
   bcf_front #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .op           (req_op),
      .value_byte   (req_value_byte),
      .address      (req_address),
      .block_length (req_block_length),
      .first_page   (req_first_page),
      .page_count   (req_page_count),
      .job_push     (job_push),
      .job          (push_job)
   );

   // Job queue
   bcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   // Back end: emit results
   bcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_valid),
      .head_job    (head_job),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== src/bcf_front.sv =====
// ----------------------------------------------------------------------------
// bcf_front
// Accepts requests, tracks the open frame and turns each item into a job.
// ----------------------------------------------------------------------------
module bcf_front #(
   parameter int MAX_BLOCK = bcf_pkg::MAX_BLOCK_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              accept,
   input  logic [2:0]        op,
   input  logic [7:0]        value_byte,
   input  logic [31:0]       address,
   input  logic [8:0]        block_length,
   input  logic [15:0]       first_page,
   input  logic [15:0]       page_count,
   output logic              job_push,
   output bcf_pkg::job_type  job
);

   logic        ext_ff, ext_in;
   logic [7:0]  csum_ff, csum_in;
   logic [8:0]  left_ff, left_in;
   logic [1:0]  pad_ff, pad_in;
   logic [15:0] page_ff, page_in;
   logic [15:0] pages_left_ff, pages_left_in;
   logic [1:0]  phase_ff, phase_in;

   // Helper values
   logic [16:0] last_page;
   logic [15:0] count_m1;
   logic [1:0]  blk_pad;
   logic [9:0]  blk_sum;
   logic [7:0]  blk_ck;
   logic [7:0]  page_ck;
   logic        range_bad;

   assign last_page = {1'b0, first_page} + {1'b0, page_count} - 17'd1;
   assign count_m1  = page_count - 16'd1;
   assign blk_pad   = 2'd0 - block_length[1:0];
   assign blk_sum   = {1'b0, block_length} + {8'd0, blk_pad} - 10'd1;
   assign blk_ck    = csum_ff ^ value_byte ^ (pad_ff[0] ? bcf_pkg::FILL_BYTE
                                                        : bcf_pkg::ZERO_BYTE);
   assign page_ck   = csum_ff ^ page_ff[7:0]
                      ^ ((phase_ff == bcf_pkg::PH_ERASE_EXT) ? page_ff[15:8] : 8'd0);
   assign range_bad = ext_ff ? (page_count > bcf_pkg::EXT_MAX_COUNT ||
                                last_page > 17'h0FFFF)
                             : (first_page > bcf_pkg::STD_MAX_PAGE ||
                                last_page > {1'b0, bcf_pkg::STD_MAX_PAGE});

   // Classify the item and compute the next frame state
   always_comb begin
      ext_in        = ext_ff;
      csum_in       = csum_ff;
      left_in       = left_ff;
      pad_in        = pad_ff;
      page_in       = page_ff;
      pages_left_in = pages_left_ff;
      phase_in      = phase_ff;
      job           = '0;
      job.kind      = bcf_pkg::KIND_TX;
      job.cnt       = bcf_pkg::CNT_W'(1);

      if (csr_wr_en) begin
         ext_in = csr_wr_data;
      end

      case (op)
         bcf_pkg::OP_COMMAND: begin
            job.cnt         = bcf_pkg::CNT_W'(2);
            job.tx_bytes[0] = value_byte;
            job.tx_bytes[1] = ~value_byte;
         end
         bcf_pkg::OP_ADDRESS: begin
            if (address[1:0] != 2'd0) begin
               job.kind = bcf_pkg::KIND_REJECT;
            end else begin
               job.cnt         = bcf_pkg::CNT_W'(5);
               job.tx_bytes[0] = address[31:24];
               job.tx_bytes[1] = address[23:16];
               job.tx_bytes[2] = address[15:8];
               job.tx_bytes[3] = address[7:0];
               job.tx_bytes[4] = address[31:24] ^ address[23:16]
                                 ^ address[15:8] ^ address[7:0];
            end
         end
         bcf_pkg::OP_BLOCK_BEGIN: begin
            if (block_length == 9'd0 || block_length > 9'(MAX_BLOCK)) begin
               job.kind = bcf_pkg::KIND_REJECT;
            end else begin
               pad_in          = blk_pad;
               left_in         = block_length;
               phase_in        = bcf_pkg::PH_BLOCK;
               csum_in         = blk_sum[7:0];
               job.tx_bytes[0] = blk_sum[7:0];
            end
         end
         bcf_pkg::OP_BLOCK_DATA: begin
            if (phase_ff != bcf_pkg::PH_BLOCK || left_ff == 9'd0) begin
               job.kind = bcf_pkg::KIND_REJECT;
            end else begin
               left_in         = left_ff - 9'd1;
               job.tx_bytes[0] = value_byte;
               if (left_ff == 9'd1) begin
                  // final byte: padding then checksum
                  job.cnt = bcf_pkg::CNT_W'({1'b0, pad_ff}) + bcf_pkg::CNT_W'(2);
                  for (int i = 1; i < bcf_pkg::MAX_RESULTS; i++) begin
                     if (3'(i) <= {1'b0, pad_ff}) begin
                        job.tx_bytes[i] = bcf_pkg::FILL_BYTE;
                     end else if (3'(i) == {1'b0, pad_ff} + 3'd1) begin
                        job.tx_bytes[i] = blk_ck;
                     end
                  end
                  csum_in  = blk_ck;
                  pad_in   = 2'd0;
                  phase_in = bcf_pkg::PH_IDLE;
               end else begin
                  csum_in = csum_ff ^ value_byte;
               end
            end
         end
         bcf_pkg::OP_ERASE_BEGIN: begin
            if (page_count == 16'd0) begin
               // empty list: close any frame, no results
               job.cnt       = '0;
               phase_in      = bcf_pkg::PH_IDLE;
               pages_left_in = 16'd0;
               left_in       = 9'd0;
               pad_in        = 2'd0;
            end else if (range_bad) begin
               job.kind = bcf_pkg::KIND_REJECT;
            end else begin
               left_in       = 9'd0;
               pad_in        = 2'd0;
               page_in       = first_page;
               pages_left_in = page_count;
               if (ext_ff) begin
                  phase_in        = bcf_pkg::PH_ERASE_EXT;
                  job.cnt         = bcf_pkg::CNT_W'(2);
                  job.tx_bytes[0] = count_m1[15:8];
                  job.tx_bytes[1] = count_m1[7:0];
                  csum_in         = count_m1[15:8] ^ count_m1[7:0];
               end else begin
                  phase_in        = bcf_pkg::PH_ERASE_STD;
                  job.tx_bytes[0] = count_m1[7:0];
                  csum_in         = count_m1[7:0];
               end
            end
         end
         bcf_pkg::OP_ERASE_PAGE: begin
            if ((phase_ff != bcf_pkg::PH_ERASE_STD && phase_ff != bcf_pkg::PH_ERASE_EXT)
                || pages_left_ff == 16'd0) begin
               job.kind = bcf_pkg::KIND_REJECT;
            end else begin
               page_in       = page_ff + 16'd1;
               pages_left_in = pages_left_ff - 16'd1;
               csum_in       = page_ck;
               if (phase_ff == bcf_pkg::PH_ERASE_EXT) begin
                  job.cnt         = bcf_pkg::CNT_W'(2);
                  job.tx_bytes[0] = page_ff[15:8];
                  job.tx_bytes[1] = page_ff[7:0];
                  job.tx_bytes[2] = page_ck;
               end else begin
                  job.tx_bytes[0] = page_ff[7:0];
                  job.tx_bytes[1] = page_ck;
               end
               if (pages_left_ff == 16'd1) begin
                  job.cnt  = job.cnt + bcf_pkg::CNT_W'(1);
                  phase_in = bcf_pkg::PH_IDLE;
               end
            end
         end
         bcf_pkg::OP_RX_BYTE: begin
            job.kind = (value_byte == bcf_pkg::ACK_CODE) ? bcf_pkg::KIND_ACK
                                                        : bcf_pkg::KIND_NACK;
         end
         bcf_pkg::OP_MASS_ERASE: begin
            job.tx_bytes[0] = bcf_pkg::FILL_BYTE;
            if (ext_ff) begin
               job.cnt         = bcf_pkg::CNT_W'(3);
               job.tx_bytes[1] = bcf_pkg::FILL_BYTE;
               job.tx_bytes[2] = bcf_pkg::ZERO_BYTE;
            end else begin
               job.cnt         = bcf_pkg::CNT_W'(2);
               job.tx_bytes[1] = bcf_pkg::ZERO_BYTE;
            end
         end
         default: begin
            job.kind = bcf_pkg::KIND_REJECT;
         end
      endcase
   end

   assign job_push = accept && (job.cnt != '0);

   // Frame state; updated only on accepted items, extended_erase on CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff        <= 1'b0;
         csum_ff       <= 8'd0;
         left_ff       <= 9'd0;
         pad_ff        <= 2'd0;
         page_ff       <= 16'd0;
         pages_left_ff <= 16'd0;
         phase_ff      <= bcf_pkg::PH_IDLE;
      end else begin
         ext_ff <= ext_in;
         if (accept) begin
            csum_ff       <= csum_in;
            left_ff       <= left_in;
            pad_ff        <= pad_in;
            page_ff       <= page_in;
            pages_left_ff <= pages_left_in;
            phase_ff      <= phase_in;
         end
      end
   end

endmodule

// ===== src/bcf_queue.sv =====
// ----------------------------------------------------------------------------
// bcf_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module bcf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bcf_pkg::job_type  push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output bcf_pkg::job_type  head_job
);

   localparam int DEPTH = 2;

   bcf_pkg::job_type      entry_ff [DEPTH];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;

   assign full       = (count_ff == 2'(DEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(push);
      rd_ptr_in = rd_ptr_ff + 1'(pop);
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/bcf_back.sv =====
// ----------------------------------------------------------------------------
// bcf_back
// Plays out one job as a run of results through the output register.
// ----------------------------------------------------------------------------
module bcf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  bcf_pkg::job_type  head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last
);

   bcf_pkg::job_type              job_ff, job_in;
   logic                          busy_ff, busy_in;
   logic [bcf_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic                          out_valid_ff, out_valid_in;
   logic [1:0]                    kind_ff;
   logic [7:0]                    byte_ff;
   logic                          last_ff;

   logic out_free;
   logic emit;
   logic done;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign done     = emit && (idx_ff == job_ff.cnt - bcf_pkg::CNT_W'(1));
   assign pop      = head_valid && (!busy_ff || done);

   // Job sequencing
   always_comb begin
      job_in       = job_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_free ? emit : out_valid_ff;
      if (emit) begin
         idx_in = idx_ff + bcf_pkg::CNT_W'(1);
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (pop) begin
         job_in  = head_job;
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         kind_ff <= job_ff.kind;
         byte_ff <= job_ff.tx_bytes[idx_ff[$clog2(bcf_pkg::MAX_RESULTS)-1:0]];
         last_ff <= (idx_ff == job_ff.cnt - bcf_pkg::CNT_W'(1));
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_last    = last_ff;

endmodule

// ===== src/bcf_checker.sv =====
// ----------------------------------------------------------------------------
// bcf_checker
// Port-level checks for the bootloader command framer.
// ----------------------------------------------------------------------------
module bcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Receive classifications and rejections stand alone
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != bcf_pkg::KIND_TX |-> rsp_last)
      else $error("non-transmit result not marked last");

   // Only transmit results carry a byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != bcf_pkg::KIND_TX |-> rsp_tx_byte == 8'd0)
      else $error("non-transmit result carries a byte");

endmodule

bind bootloader_command_framer bcf_checker u_bcf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_kind    (rsp_kind),
   .rsp_tx_byte (rsp_tx_byte),
   .rsp_last    (rsp_last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bootloader command framer. A short table of
// requests hits the field extremes, every opcode and each reject path, with
// fixed expectations where the bytes are obvious. Random block, erase and
// side traffic follows under three idle mixes. All other results are compared
// against an in-bench framing predictor.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_PRINTS    = 40;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  vb;
      logic [31:0] addr;
      logic [8:0]  blen;
      logic [15:0] first;
      logic [15:0] count;
   } frame_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic       last;
   } frame_out_type;

   // One line of the directed table; bytes holds the first result in its top byte
   typedef struct packed {
      logic          is_cfg;
      frame_req_type item;
      logic          typed;
      logic [1:0]    kind;
      logic [2:0]    n;
      logic [39:0]   bytes;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [7:0]  req_value_byte = '0;
   logic [31:0] req_address = '0;
   logic [8:0]  req_block_length = '0;
   logic [15:0] req_first_page = '0;
   logic [15:0] req_page_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;

   bootloader_command_framer #(
      .MAX_BLOCK(bcf_pkg::MAX_BLOCK_DEF)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_value_byte  (req_value_byte),
      .req_address     (req_address),
      .req_block_length(req_block_length),
      .req_first_page  (req_first_page),
      .req_page_count  (req_page_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last)
   );

   // Framer state as the bench sees it
   logic        ext_erase = 1'b0;
   logic [7:0]  xor_sum = '0;
   logic [8:0]  data_left = '0;
   logic [1:0]  fill_left = '0;
   logic [15:0] page_next = '0;
   logic [15:0] pages_todo = '0;
   logic [1:0]  frame_phase = bcf_pkg::PH_IDLE;

   frame_out_type predicted[$];
   frame_out_type awaited_out[$];

   int snd_idle_pct = 14;
   int rcv_stall_pct = 74;
   int items_sent = 0;
   int outs_checked = 0;
   int err_count = 0;
   int kind_seen[4] = '{0, 0, 0, 0};

   always #5 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // ---- predictor ----------------------------------------------------------
   function automatic void add_out(input logic [1:0] kind, input logic [7:0] b);
      frame_out_type o;
      o.kind    = kind;
      o.tx_byte = b;
      o.last    = 1'b0;
      predicted.push_back(o);
   endfunction

   // Transmit bytes that belong to the checksum
   function automatic void add_tx(input logic [7:0] b);
      xor_sum = xor_sum ^ b;
      add_out(bcf_pkg::KIND_TX, b);
   endfunction

   function automatic void frame_item(input frame_req_type it);
      logic [31:0] last_pg;
      logic [15:0] cnt_m1;
      logic [8:0]  len_byte;
      logic        bad;
      predicted.delete();
      case (it.op)
         bcf_pkg::OP_COMMAND: begin
            add_out(bcf_pkg::KIND_TX, it.vb);
            add_out(bcf_pkg::KIND_TX, ~it.vb);
         end
         bcf_pkg::OP_ADDRESS: begin
            if (it.addr[1:0] != 2'b00) begin
               add_out(bcf_pkg::KIND_REJECT, bcf_pkg::ZERO_BYTE);
            end else begin
               for (int i = 0; i < 4; i++)
                  add_out(bcf_pkg::KIND_TX, it.addr[31-8*i -: 8]);
               add_out(bcf_pkg::KIND_TX, it.addr[31:24] ^ it.addr[23:16]
                                         ^ it.addr[15:8] ^ it.addr[7:0]);
            end
         end
         bcf_pkg::OP_BLOCK_BEGIN: begin
            if (it.blen == 9'd0 || it.blen > bcf_pkg::MAX_BLOCK_DEF) begin
               add_out(bcf_pkg::KIND_REJECT, bcf_pkg::ZERO_BYTE);
            end else begin
               fill_left   = -it.blen[1:0];
               data_left   = it.blen;
               frame_phase = bcf_pkg::PH_BLOCK;
               xor_sum     = '0;
               len_byte    = it.blen + {7'd0, fill_left} - 9'd1;
               add_tx(len_byte[7:0]);
            end
         end
         bcf_pkg::OP_BLOCK_DATA: begin
            if (frame_phase != bcf_pkg::PH_BLOCK || data_left == 9'd0) begin
               add_out(bcf_pkg::KIND_REJECT, bcf_pkg::ZERO_BYTE);
            end else begin
               add_tx(it.vb);
               data_left--;
               if (data_left == 9'd0) begin
                  for (int i = 0; i < fill_left; i++) add_tx(bcf_pkg::FILL_BYTE);
                  fill_left = '0;
                  add_out(bcf_pkg::KIND_TX, xor_sum);
                  frame_phase = bcf_pkg::PH_IDLE;
               end
            end
         end
         bcf_pkg::OP_ERASE_BEGIN: begin
            if (it.count == 16'd0) begin
               // empty list: closes any frame, emits nothing
               frame_phase = bcf_pkg::PH_IDLE;
               pages_todo  = '0;
               data_left   = '0;
               fill_left   = '0;
            end else begin
               last_pg = {16'd0, it.first} + {16'd0, it.count} - 32'd1;
               if (ext_erase)
                  bad = (it.count > bcf_pkg::EXT_MAX_COUNT) || (last_pg > 32'hFFFF);
               else
                  bad = (it.first > bcf_pkg::STD_MAX_PAGE)
                        || (last_pg > {16'd0, bcf_pkg::STD_MAX_PAGE});
               if (bad) begin
                  add_out(bcf_pkg::KIND_REJECT, bcf_pkg::ZERO_BYTE);
               end else begin
                  xor_sum    = '0;
                  data_left  = '0;
                  fill_left  = '0;
                  page_next  = it.first;
                  pages_todo = it.count;
                  cnt_m1     = it.count - 16'd1;
                  if (ext_erase) begin
                     frame_phase = bcf_pkg::PH_ERASE_EXT;
                     add_tx(cnt_m1[15:8]);
                  end else begin
                     frame_phase = bcf_pkg::PH_ERASE_STD;
                  end
                  add_tx(cnt_m1[7:0]);
               end
            end
         end
         bcf_pkg::OP_ERASE_PAGE: begin
            if ((frame_phase != bcf_pkg::PH_ERASE_STD
                 && frame_phase != bcf_pkg::PH_ERASE_EXT)
                || pages_todo == 16'd0) begin
               add_out(bcf_pkg::KIND_REJECT, bcf_pkg::ZERO_BYTE);
            end else begin
               if (frame_phase == bcf_pkg::PH_ERASE_EXT) add_tx(page_next[15:8]);
               add_tx(page_next[7:0]);
               page_next++;
               pages_todo--;
               if (pages_todo == 16'd0) begin
                  add_out(bcf_pkg::KIND_TX, xor_sum);
                  frame_phase = bcf_pkg::PH_IDLE;
               end
            end
         end
         bcf_pkg::OP_RX_BYTE: begin
            add_out((it.vb == bcf_pkg::ACK_CODE) ? bcf_pkg::KIND_ACK : bcf_pkg::KIND_NACK,
                    bcf_pkg::ZERO_BYTE);
         end
         default: begin
            add_out(bcf_pkg::KIND_TX, bcf_pkg::FILL_BYTE);
            if (ext_erase) add_out(bcf_pkg::KIND_TX, bcf_pkg::FILL_BYTE);
            add_out(bcf_pkg::KIND_TX, bcf_pkg::ZERO_BYTE);
         end
      endcase
      if (predicted.size() > 0) predicted[predicted.size()-1].last = 1'b1;
   endfunction

   // ---- result checker -----------------------------------------------------
   always @(posedge clock) begin : check_out
      frame_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_out.size() == 0) begin
            report_mismatch("result with nothing pending (kind)", 32'(rsp_kind), 32'd0);
         end else begin
            want = awaited_out.pop_front();
            outs_checked++;
            kind_seen[want.kind]++;
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            if (rsp_tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", 32'(rsp_tx_byte), 32'(want.tx_byte));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // ---- request driving ----------------------------------------------------
   // Valid stays high into the next item unless a gap is drawn
   task automatic send_item(input frame_req_type it);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_valid        <= 1'b1;
      req_op           <= it.op;
      req_value_byte   <= it.vb;
      req_address      <= it.addr;
      req_block_length <= it.blen;
      req_first_page   <= it.first;
      req_page_count   <= it.count;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic issue(input frame_req_type it);
      send_item(it);
      frame_item(it);
      foreach (predicted[i]) awaited_out.push_back(predicted[i]);
   endtask

   // Drop valid, let all results drain, then allow for items with no result
   task automatic quiesce();
      req_valid <= 1'b0;
      while (awaited_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ext(input logic v);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ext_erase = v;
   endtask

   // ---- random traffic -----------------------------------------------------
   function automatic frame_req_type noise_item();
      frame_req_type it;
      it.op    = 3'($urandom_range(7));
      it.vb    = 8'($urandom_range(255));
      it.addr  = $urandom;
      it.blen  = 9'($urandom_range(511));
      it.first = 16'($urandom_range(16'hFFFF));
      it.count = 16'($urandom_range(16'hFFFF));
      return it;
   endfunction

   // Requests that leave an open frame alone
   function automatic frame_req_type side_item();
      frame_req_type it;
      it = noise_item();
      case ($urandom_range(3))
         0: it.op = bcf_pkg::OP_COMMAND;
         1: begin
            it.op = bcf_pkg::OP_ADDRESS;
            if ($urandom_range(4) != 0) it.addr[1:0] = 2'b00;
         end
         2: begin
            it.op = bcf_pkg::OP_RX_BYTE;
            if ($urandom_range(1) == 0) it.vb = bcf_pkg::ACK_CODE;
         end
         default: it.op = bcf_pkg::OP_MASS_ERASE;
      endcase
      return it;
   endfunction

   task automatic maybe_side();
      if ($urandom_range(99) < 10) issue(side_item());
   endtask

   task automatic block_seq();
      int len;
      int pick;
      frame_req_type it;
      pick = $urandom_range(99);
      if (pick < 80) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 32);
      else len = $urandom_range(33, 64);
      it = noise_item();
      it.op = bcf_pkg::OP_BLOCK_BEGIN;
      it.blen = 9'(len);
      issue(it);
      for (int i = 0; i < len; i++) begin
         maybe_side();
         // occasionally abandon the block part way
         if ($urandom_range(99) < 3) return;
         it = noise_item();
         it.op = bcf_pkg::OP_BLOCK_DATA;
         issue(it);
      end
      if ($urandom_range(99) < 10) begin
         it = noise_item();
         it.op = bcf_pkg::OP_BLOCK_DATA;
         issue(it);
      end
   endtask

   task automatic erase_seq();
      int cnt;
      int lim;
      frame_req_type it;
      cnt = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      lim = ext_erase ? 65536 : 256;
      it = noise_item();
      it.op = bcf_pkg::OP_ERASE_BEGIN;
      it.count = 16'(cnt);
      it.first = ($urandom_range(99) < 20) ? 16'(lim - cnt)
                                           : 16'($urandom_range(lim - cnt));
      issue(it);
      for (int i = 0; i < cnt; i++) begin
         maybe_side();
         if ($urandom_range(99) < 3) return;
         it = noise_item();
         it.op = bcf_pkg::OP_ERASE_PAGE;
         issue(it);
      end
      if ($urandom_range(99) < 10) begin
         it = noise_item();
         it.op = bcf_pkg::OP_ERASE_PAGE;
         issue(it);
      end
   endtask

   task automatic run_random(input int n, input int snd_pct, input int rcv_pct);
      int stop;
      int pick;
      snd_idle_pct  = snd_pct;
      rcv_stall_pct = rcv_pct;
      stop = items_sent + n;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 40) block_seq();
         else if (pick < 70) erase_seq();
         else if (pick < 85) issue(side_item());
         else issue(noise_item());
      end
   endtask

   // ---- directed table helpers ---------------------------------------------
   function automatic frame_req_type req(input logic [2:0] op, input logic [7:0] vb,
                                         input logic [31:0] addr, input logic [8:0] blen,
                                         input logic [15:0] first,
                                         input logic [15:0] count);
      frame_req_type it;
      it.op = op;
      it.vb = vb;
      it.addr = addr;
      it.blen = blen;
      it.first = first;
      it.count = count;
      return it;
   endfunction

   function automatic script_row_type chk_row(input frame_req_type it,
                                              input logic [1:0] kind,
                                              input logic [2:0] n,
                                              input logic [39:0] bytes);
      script_row_type r;
      r.is_cfg = 1'b0;
      r.item   = it;
      r.typed  = 1'b1;
      r.kind   = kind;
      r.n      = n;
      r.bytes  = bytes;
      return r;
   endfunction

   function automatic script_row_type pred_row(input frame_req_type it);
      script_row_type r;
      r = chk_row(it, bcf_pkg::KIND_TX, 3'd0, '0);
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic script_row_type cfg_row(input logic v);
      script_row_type r;
      r = pred_row(req(bcf_pkg::OP_COMMAND, {7'd0, v}, 0, 0, 0, 0));
      r.is_cfg = 1'b1;
      return r;
   endfunction

   // ---- run ----------------------------------------------------------------
   initial begin
      script_row_type script[$];
      frame_out_type  o;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // commands, addresses, blocks and standard erase framing after reset
      script.push_back(chk_row(req(bcf_pkg::OP_COMMAND, 8'h00, 0, 0, 0, 0),
                               bcf_pkg::KIND_TX, 3'd2, 40'h00FF_000000));
      script.push_back(chk_row(req(bcf_pkg::OP_COMMAND, 8'hFF, 0, 0, 0, 0),
                               bcf_pkg::KIND_TX, 3'd2, 40'hFF00_000000));
      script.push_back(chk_row(req(bcf_pkg::OP_ADDRESS, 8'h00, 32'hFFFF_FFFC, 0, 0, 0),
                               bcf_pkg::KIND_TX, 3'd5, 40'hFFFFFFFC03));
      script.push_back(chk_row(req(bcf_pkg::OP_ADDRESS, 8'h00, 32'h0000_0003, 0, 0, 0),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(chk_row(req(bcf_pkg::OP_BLOCK_DATA, 8'h5A, 0, 0, 0, 0),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(chk_row(req(bcf_pkg::OP_BLOCK_BEGIN, 8'h00, 0, 9'd0, 0, 0),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(chk_row(req(bcf_pkg::OP_BLOCK_BEGIN, 8'h00, 0, 9'd257, 0, 0),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(chk_row(req(bcf_pkg::OP_BLOCK_BEGIN, 8'h00, 0, 9'd1, 0, 0),
                               bcf_pkg::KIND_TX, 3'd1, 40'h03 << 32));
      // ACK inside an open block, then the single data byte with padding
      script.push_back(chk_row(req(bcf_pkg::OP_RX_BYTE, bcf_pkg::ACK_CODE, 0, 0, 0, 0),
                               bcf_pkg::KIND_ACK, 3'd1, '0));
      script.push_back(pred_row(req(bcf_pkg::OP_BLOCK_DATA, 8'hA5, 0, 0, 0, 0)));
      script.push_back(chk_row(req(bcf_pkg::OP_BLOCK_BEGIN, 8'h00, 0, 9'd256, 0, 0),
                               bcf_pkg::KIND_TX, 3'd1, 40'hFF << 32));
      // empty erase list closes the open block silently
      script.push_back(pred_row(req(bcf_pkg::OP_ERASE_BEGIN, 8'h00, 0, 0, 16'd0, 16'd0)));
      script.push_back(chk_row(req(bcf_pkg::OP_BLOCK_DATA, 8'h11, 0, 0, 0, 0),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(chk_row(req(bcf_pkg::OP_ERASE_BEGIN, 8'h00, 0, 0, 16'd255, 16'd2),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(pred_row(req(bcf_pkg::OP_ERASE_BEGIN, 8'h00, 0, 0, 16'd254, 16'd2)));
      script.push_back(pred_row(req(bcf_pkg::OP_ERASE_PAGE, 8'h00, 0, 0, 0, 0)));
      script.push_back(chk_row(req(bcf_pkg::OP_MASS_ERASE, 8'h00, 0, 0, 0, 0),
                               bcf_pkg::KIND_TX, 3'd2, 40'hFF00_000000));
      script.push_back(pred_row(req(bcf_pkg::OP_ERASE_PAGE, 8'h00, 0, 0, 0, 0)));
      script.push_back(chk_row(req(bcf_pkg::OP_ERASE_PAGE, 8'h00, 0, 0, 0, 0),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(chk_row(req(bcf_pkg::OP_RX_BYTE, 8'h78, 0, 0, 0, 0),
                               bcf_pkg::KIND_NACK, 3'd1, '0));
      // extended erase framing
      script.push_back(cfg_row(1'b1));
      script.push_back(chk_row(req(bcf_pkg::OP_ERASE_BEGIN, 8'h00, 0, 0, 16'd0, 16'hFFF1),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(chk_row(req(bcf_pkg::OP_ERASE_BEGIN, 8'h00, 0, 0, 16'hFFFF, 16'd2),
                               bcf_pkg::KIND_REJECT, 3'd1, '0));
      script.push_back(pred_row(req(bcf_pkg::OP_ERASE_BEGIN, 8'h00, 0, 0,
                                    16'hFFFE, 16'd2)));
      script.push_back(pred_row(req(bcf_pkg::OP_ERASE_PAGE, 8'h00, 0, 0, 0, 0)));
      script.push_back(chk_row(req(bcf_pkg::OP_MASS_ERASE, 8'h00, 0, 0, 0, 0),
                               bcf_pkg::KIND_TX, 3'd3, 40'hFFFF00_0000));
      // restart abandons the half-sent list
      script.push_back(pred_row(req(bcf_pkg::OP_ERASE_BEGIN, 8'h00, 0, 0, 16'd0,
                                    bcf_pkg::EXT_MAX_COUNT)));
      script.push_back(cfg_row(1'b0));

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            write_ext(script[i].item.vb[0]);
         end else begin
            send_item(script[i].item);
            frame_item(script[i].item);
            if (script[i].typed) begin
               for (int k = 0; k < script[i].n; k++) begin
                  o.kind    = script[i].kind;
                  o.tx_byte = script[i].bytes[39-8*k -: 8];
                  o.last    = (k == script[i].n - 1);
                  awaited_out.push_back(o);
               end
            end else begin
               foreach (predicted[j]) awaited_out.push_back(predicted[j]);
            end
         end
      end

      write_ext(1'b1);
      run_random(100, 14, 74);
      write_ext(1'b0);
      run_random(100, 74, 14);
      write_ext(1'($urandom_range(1)));
      run_random(100, 0, 0);
      quiesce();

      $display("Sent %0d items: directed table, then random blocks, erase lists and side",
               items_sent);
      $display("requests in both framings; %0d results (%0d tx, %0d ack, %0d nack, %0d rej)",
               outs_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("%0d mismatches", err_count);
      if (err_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Timed out with %0d results still pending", awaited_out.size());
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
